>>> rtl/core/hmq_pkg.sv
// ----------------------------------------------------------------------------
// hmq_pkg
// Shared types and constants of the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package hmq_pkg;

   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 48;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_CMP,
      ST_DN_LAST,
      ST_DN_LOAD,
      ST_DN_READ,
      ST_DN_CMP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_parent;
      logic rd_last;
      logic rd_children;
      logic wr_key;
      logic wr_up;
      logic wr_down;
      logic ld_last;
      logic inc;
      logic dec;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic req_remove;
      logic full;
      logic empty;
      logic node_zero;
      logic key_lt_parent;
      logic left_ok;
      logic down_move;
      logic slot_free;
   } stat_type;

endpackage

>>> rtl/core/hmq_ram.sv
// ----------------------------------------------------------------------------
// hmq_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module hmq_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   output logic [WIDTH-1:0]  rd_a_data,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [WIDTH-1:0]  rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

>>> rtl/core/hmq_datapath.sv
// ----------------------------------------------------------------------------
// hmq_datapath
// Key store, sift registers, index arithmetic, compares and result register.
// ----------------------------------------------------------------------------
module hmq_datapath
   import hmq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          st,
   input  logic              req_tuser,
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;

   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           node_ff, node_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] root_ff;
   status_type              status_ff, status_in;

   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic signed [KEY_W-1:0] rsp_top_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic                    rsp_full_ff;
   logic                    rsp_empty_ff;

   logic signed [KEY_W-1:0] rd_a, rd_b;
   logic [KEY_W-1:0]        rd_a_raw, rd_b_raw;
   logic [AW-1:0]           rd_a_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic signed [KEY_W-1:0] wr_data;

   logic [AW-1:0]           parent_idx;
   logic [AW-1:0]           last_idx;
   logic [IW-1:0]           left_idx, right_idx, count_ext;
   logic                    left_ok, right_ok, lt_left, lt_right;
   logic signed [KEY_W-1:0] best_key;
   logic [AW-1:0]           best_idx;
   logic                    is_full, is_empty;

   hmq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY),
      .ADDR_W(AW)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_a_addr(rd_a_addr),
      .rd_a_data(rd_a_raw),
      .rd_b_addr(right_idx[AW-1:0]),
      .rd_b_data(rd_b_raw)
   );

   assign rd_a = $signed(rd_a_raw);
   assign rd_b = $signed(rd_b_raw);

   // heap index arithmetic
   assign parent_idx = AW'((node_ff - AW'(1)) >> 1);
   assign last_idx   = AW'(count_ff - CW'(1));
   assign left_idx   = {1'b0, node_ff, 1'b1};
   assign right_idx  = left_idx + IW'(1);
   assign count_ext  = IW'(count_ff);
   assign left_ok    = left_idx < count_ext;
   assign right_ok   = right_idx < count_ext;
   assign is_full    = count_ff == CW'(CAPACITY);
   assign is_empty   = count_ff == '0;

   // smaller child, left wins ties, moves only when strictly below the key
   always_comb begin
      lt_left  = rd_a < key_ff;
      best_key = lt_left ? rd_a : key_ff;
      lt_right = 1'b0;
      if (right_ok && (rd_b < best_key)) begin
         lt_right = 1'b1;
      end
      best_idx = lt_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
   end

   always_comb begin
      priority if (cmd.rd_parent) begin
         rd_a_addr = parent_idx;
      end else if (cmd.rd_last) begin
         rd_a_addr = last_idx;
      end else if (cmd.rd_children) begin
         rd_a_addr = left_idx[AW-1:0];
      end else begin
         rd_a_addr = '0;
      end
   end

   always_comb begin
      wr_en   = cmd.wr_key | cmd.wr_up | cmd.wr_down;
      wr_addr = node_ff;
      priority if (cmd.wr_up) begin
         wr_data = rd_a;
      end else if (cmd.wr_down) begin
         wr_data = lt_right ? rd_b : rd_a;
      end else begin
         wr_data = key_ff;
      end
   end

   always_comb begin
      count_in  = count_ff;
      node_in   = node_ff;
      key_in    = key_ff;
      status_in = status_ff;
      if (cmd.load) begin
         key_in  = $signed(req_tdata[KEY_W-1:0]);
         node_in = count_ff[AW-1:0];
         priority if (opcode_type'(req_tuser) == OP_INSERT && is_full) begin
            status_in = STATUS_FULL;
         end else if (opcode_type'(req_tuser) == OP_REMOVE && is_empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            status_in = STATUS_OK;
         end
      end
      if (cmd.inc) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.dec) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.ld_last) begin
         key_in  = rd_a;
         node_in = '0;
      end
      if (cmd.wr_up) begin
         node_in = parent_idx;
      end
      if (cmd.wr_down) begin
         node_in = best_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff   <= node_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      if (wr_en && wr_addr == '0) begin
         root_ff <= wr_data;
      end
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         rsp_top_ff    <= is_empty ? '0 : root_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_full_ff   <= is_full;
         rsp_empty_ff  <= is_empty;
      end
   end

   assign st.req_remove    = opcode_type'(req_tuser) == OP_REMOVE;
   assign st.full          = is_full;
   assign st.empty         = is_empty;
   assign st.node_zero     = node_ff == '0;
   assign st.key_lt_parent = key_ff < rd_a;
   assign st.left_ok       = left_ok;
   assign st.down_move     = left_ok && (lt_left || lt_right);
   assign st.slot_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_empty_ff, rsp_full_ff, rsp_count_ff, rsp_top_ff,
                        rsp_status_ff};

endmodule

>>> rtl/core/hmq_ctrl.sv
// ----------------------------------------------------------------------------
// hmq_ctrl
// Controller that steps the datapath through insert sift-up and remove
// sift-down, one heap level per read and compare.
// ----------------------------------------------------------------------------
module hmq_ctrl
   import hmq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type st,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               priority if (st.req_remove && st.empty) begin
                  state_in = ST_FINISH;
               end else if (st.req_remove) begin
                  state_in = ST_DN_LAST;
               end else if (st.full) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_UP_READ;
               end
            end
         end
         ST_UP_READ: begin
            if (st.node_zero) begin
               cmd.wr_key = 1'b1;
               cmd.inc    = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (st.key_lt_parent) begin
               cmd.wr_up = 1'b1;
               state_in  = ST_UP_READ;
            end else begin
               cmd.wr_key = 1'b1;
               cmd.inc    = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_DN_LAST: begin
            cmd.rd_last = 1'b1;
            cmd.dec     = 1'b1;
            state_in    = ST_DN_LOAD;
         end
         ST_DN_LOAD: begin
            if (st.empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.ld_last = 1'b1;
               state_in    = ST_DN_READ;
            end
         end
         ST_DN_READ: begin
            cmd.rd_children = 1'b1;
            if (st.left_ok) begin
               state_in = ST_DN_CMP;
            end else begin
               cmd.wr_key = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_DN_CMP: begin
            if (st.down_move) begin
               cmd.wr_down = 1'b1;
               state_in    = ST_DN_READ;
            end else begin
               cmd.wr_key = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (st.slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue of signed Q16.16 keys: insert sifts up, remove
// moves the last key to the root and sifts down, one result per item.
// ----------------------------------------------------------------------------
// levels: insert and remove walk L levels, L at most log2(CAPACITY);
//    one key store read and compare per level
// throughput: one item at a time, next item taken once the result is queued
// reset: synchronous, clears the count, controller and result valid;
//    key store contents are not cleared
module binary_min_heap_queue
   import hmq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // key[31:0]
   input  logic             req_tuser,  // opcode[0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // status, top_key, count, full_res, empty_res
);

   cmd_type  cmd;
   stat_type st;

   hmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .st        (st),
      .cmd       (cmd)
   );

   hmq_datapath #(
      .CAPACITY(CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> rtl/core/hmq_checker.sv
// ----------------------------------------------------------------------------
// hmq_checker
// Port-level checks of the heap queue result stream.
// ----------------------------------------------------------------------------
module hmq_checker
   import hmq_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // empty heap reports zero top key and zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[40] |-> rsp_tdata[33:2] == '0 && rsp_tdata[38:34] == '0)
      else $error("empty heap with nonzero top or count");

   // full status only when the heap is full, empty status only when empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == STATUS_FULL |-> rsp_tdata[39])
      else $error("full status without full flag");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == STATUS_EMPTY |-> rsp_tdata[40])
      else $error("empty status without empty flag");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind binary_min_heap_queue hmq_checker u_checker (.*);

>>> verif/tb_binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// tb_binary_min_heap_queue
// Self-checking bench for the min-heap priority queue. A directed table walks
// the empty and full corners, the key extremes and equal keys, then random
// insert/remove phases swing the heap between empty and full. Every result
// is compared field by field against a row's expected values or a behavioral heap in the bench.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_queue;
   import hmq_pkg::*;

   localparam int HEAP_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 1950;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      status_type       status;
      logic [KEY_W-1:0] top_key;
      logic [COUNT_W-1:0] count;
      logic             full_flag;
      logic             empty_flag;
   } heap_result_type;

   typedef struct {
      opcode_type       op;
      logic [KEY_W-1:0] key;
      bit               has_exp;
      heap_result_type  exp;
   } stim_row_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;  // key[31:0]
   logic             req_tuser  = 1'b0; // opcode[0]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;  // status[1:0], top_key[33:2], count[38:34], full[39], empty[40]

   logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
   int              heap_count = 0;
   heap_result_type results_due[$];
   stim_row_type    directed_rows[$];

   int mismatch_count  = 0;
   int results_checked = 0;
   int n_insert = 0, n_remove = 0, n_full_drop = 0, n_empty_refuse = 0;
   int burst_left = 0;
   int stall_left = 0;
   int stall_mode = 0;
   int cycle_count = 0;

   binary_min_heap_queue #(.CAPACITY(HEAP_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic heap_result_type heap_apply(input opcode_type op,
                                                  input logic [KEY_W-1:0] key);
      heap_result_type r;
      int node, up, lchild, rchild, best;
      logic signed [KEY_W-1:0] tmp;
      r.status = STATUS_OK;
      if (op == OP_INSERT) begin
         n_insert++;
         if (heap_count >= HEAP_DEPTH) begin
            r.status = STATUS_FULL;
            n_full_drop++;
         end else begin
            node = heap_count;
            heap_keys[node] = key;
            while (node > 0) begin
               up = (node - 1) / 2;
               if (heap_keys[node] < heap_keys[up]) begin
                  tmp = heap_keys[node];
                  heap_keys[node] = heap_keys[up];
                  heap_keys[up] = tmp;
                  node = up;
               end else begin
                  break;
               end
            end
            heap_count++;
         end
      end else begin
         n_remove++;
         if (heap_count == 0) begin
            r.status = STATUS_EMPTY;
            n_empty_refuse++;
         end else begin
            heap_keys[0] = heap_keys[heap_count - 1];
            heap_count--;
            node = 0;
            while (node < heap_count) begin
               lchild = 2 * node + 1;
               rchild = 2 * node + 2;
               best = node;
               // left child wins ties, equal keys stay put
               if (lchild < heap_count && heap_keys[lchild] < heap_keys[best])
                  best = lchild;
               if (rchild < heap_count && heap_keys[rchild] < heap_keys[best])
                  best = rchild;
               if (best == node)
                  break;
               tmp = heap_keys[node];
               heap_keys[node] = heap_keys[best];
               heap_keys[best] = tmp;
               node = best;
            end
         end
      end
      r.top_key    = (heap_count != 0) ? heap_keys[0] : '0;
      r.count      = heap_count[COUNT_W-1:0];
      r.full_flag  = (heap_count == HEAP_DEPTH);
      r.empty_flag = (heap_count == 0);
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] v;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         // whole Q16.16 values near zero, many equal keys
         1, 2: v = ($urandom_range(0, 6) - 3) << 16;
         3: v = $urandom_range(0, 15);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic add_row(input opcode_type op, input logic [KEY_W-1:0] key);
      stim_row_type row;
      row.op      = op;
      row.key     = key;
      row.has_exp = 1'b0;
      row.exp     = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_checked_row(input opcode_type op, input logic [KEY_W-1:0] key,
                                  input status_type status, input logic [KEY_W-1:0] top,
                                  input int count, input bit full_flag, input bit empty_flag);
      stim_row_type row;
      row.op      = op;
      row.key     = key;
      row.has_exp = 1'b1;
      row.exp     = '{status, top, count[COUNT_W-1:0], full_flag, empty_flag};
      directed_rows.push_back(row);
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic put_item(input opcode_type op, input logic [KEY_W-1:0] key,
                           input bit has_exp, input heap_result_type exp_in);
      heap_result_type predicted;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
         gap = 0;
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      predicted = heap_apply(op, key);
      results_due.push_back(has_exp ? exp_in : predicted);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(1, 40);
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (stall_left == 1);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
      stall_left--;
   end

   always @(posedge clock) begin
      heap_result_type want;
      heap_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status     = status_type'(rsp_tdata[1:0]);
         got.top_key    = rsp_tdata[33:2];
         got.count      = rsp_tdata[38:34];
         got.full_flag  = rsp_tdata[39];
         got.empty_flag = rsp_tdata[40];
         if (results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: status=%0d top=%h count=%0d full=%b empty=%b",
                        got.status, got.top_key, got.count, got.full_flag,
                        got.empty_flag);
         end else begin
            want = results_due.pop_front();
            results_checked++;
            if (got.status !== want.status || got.top_key !== want.top_key ||
                got.count !== want.count || got.full_flag !== want.full_flag ||
                got.empty_flag !== want.empty_flag) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("result %0d mismatch: exp status=%0d top=%h count=%0d full=%b empty=%b",
                           results_checked, want.status, want.top_key, want.count,
                           want.full_flag, want.empty_flag);
                  $display("                   got status=%0d top=%h count=%0d full=%b empty=%b",
                           got.status, got.top_key, got.count, got.full_flag,
                           got.empty_flag);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, results_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      opcode_type op;
      int insert_pct;
      int phase_left;
      stim_row_type row;

      add_checked_row(OP_REMOVE, 32'h0000_0000, STATUS_EMPTY, 32'h0000_0000, 0, 1'b0, 1'b1);
      add_checked_row(OP_INSERT, 32'h7FFF_FFFF, STATUS_OK, 32'h7FFF_FFFF, 1, 1'b0, 1'b0);
      add_checked_row(OP_INSERT, 32'h8000_0000, STATUS_OK, 32'h8000_0000, 2, 1'b0, 1'b0);
      add_checked_row(OP_REMOVE, 32'hFFFF_FFFF, STATUS_OK, 32'h7FFF_FFFF, 1, 1'b0, 1'b0);
      add_checked_row(OP_REMOVE, 32'h0000_0000, STATUS_OK, 32'h0000_0000, 0, 1'b0, 1'b1);
      add_row(OP_INSERT, 32'h0001_0000);
      add_row(OP_INSERT, 32'h0001_0000);
      add_row(OP_INSERT, 32'h0001_0000);
      add_row(OP_INSERT, 32'hFFFF_0000);
      add_row(OP_INSERT, 32'h7FFF_FFFF);
      add_row(OP_INSERT, 32'h8000_0000);
      add_row(OP_INSERT, 32'h0000_0000);
      add_row(OP_INSERT, 32'hFFFF_FFFF);
      add_row(OP_INSERT, 32'h0001_0000);
      add_row(OP_INSERT, 32'h8000_0000);
      add_row(OP_INSERT, 32'h7FFF_FFFE);
      add_row(OP_INSERT, 32'hFFFF_0000);
      add_row(OP_INSERT, 32'h0000_0001);
      add_row(OP_INSERT, 32'h8000_0001);
      add_row(OP_INSERT, 32'h0002_0000);
      add_row(OP_INSERT, 32'hFFFE_0000);
      add_checked_row(OP_INSERT, 32'h0000_0000, STATUS_FULL, 32'h8000_0000, 16, 1'b1, 1'b0);
      add_row(OP_REMOVE, 32'hAAAA_AAAA);
      add_row(OP_INSERT, 32'h1234_5678);
      add_checked_row(OP_INSERT, 32'h5555_5555, STATUS_FULL, 32'h8000_0000, 16, 1'b1, 1'b0);

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         put_item(row.op, row.key, row.has_exp, row.exp);
      end

      // phases lean toward insert or remove so the heap swings between
      // empty and full, with balanced stretches in between
      phase_left = 0;
      insert_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0: insert_pct = 85;
               1: insert_pct = 50;
               default: insert_pct = 15;
            endcase
         end
         phase_left--;
         op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
         put_item(op, pick_key(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d items: %0d inserts (%0d dropped on full), %0d removes (%0d refused on empty)",
               n_insert + n_remove, n_insert, n_full_drop, n_remove, n_empty_refuse);
      $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/hmq_pkg.sv
rtl/core/hmq_ram.sv
rtl/core/hmq_datapath.sv
rtl/core/hmq_ctrl.sv
rtl/core/binary_min_heap_queue.sv
rtl/core/hmq_checker.sv
verif/tb_binary_min_heap_queue.sv
